// File: rtl/core/sts_pkg.sv
// ----------------------------------------------------------------------------
// sts_pkg
// Shared types, character codes and result helpers for the token scanner.
// ----------------------------------------------------------------------------
package sts_pkg;

  localparam int unsigned CP_W    = 21;
  localparam int unsigned VALUE_W = 64;
  localparam int unsigned LINE_W  = 24;
  localparam int unsigned COL_W   = 16;
  localparam int unsigned TAB_W   = 5;
  localparam int unsigned PAD_W   = VALUE_W - CP_W;

  localparam logic [TAB_W-1:0]  TAB_RESET = 5'd4;
  localparam logic [LINE_W-1:0] LINE_MAX  = '1;
  localparam logic [COL_W-1:0]  COL_MAX   = '1;
  localparam logic [LINE_W-1:0] LINE_ONE  = 24'd1;

  localparam logic [CP_W-1:0] ASCII_MAX     = 21'h7F;
  localparam logic [CP_W-1:0] CH_TAB        = 21'd9;
  localparam logic [CP_W-1:0] CH_LF         = 21'd10;
  localparam logic [CP_W-1:0] CH_CR         = 21'd13;
  localparam logic [CP_W-1:0] CH_SPACE      = 21'd32;
  localparam logic [CP_W-1:0] CH_QUOTE      = 21'd34;
  localparam logic [CP_W-1:0] CH_APOS       = 21'd39;
  localparam logic [CP_W-1:0] CH_LPAREN     = 21'd40;
  localparam logic [CP_W-1:0] CH_RPAREN     = 21'd41;
  localparam logic [CP_W-1:0] CH_COMMA      = 21'd44;
  localparam logic [CP_W-1:0] CH_DOT        = 21'd46;
  localparam logic [CP_W-1:0] CH_ZERO       = 21'd48;
  localparam logic [CP_W-1:0] CH_NINE       = 21'd57;
  localparam logic [CP_W-1:0] CH_SEMI       = 21'd59;
  localparam logic [CP_W-1:0] CH_EQUAL      = 21'd61;
  localparam logic [CP_W-1:0] CH_GREATER    = 21'd62;
  localparam logic [CP_W-1:0] CH_UPPER_A    = 21'd65;
  localparam logic [CP_W-1:0] CH_UPPER_Z    = 21'd90;
  localparam logic [CP_W-1:0] CH_BACKSLASH  = 21'd92;
  localparam logic [CP_W-1:0] CH_UNDERSCORE = 21'd95;
  localparam logic [CP_W-1:0] CH_LOWER_A    = 21'd97;
  localparam logic [CP_W-1:0] CH_LOWER_B    = 21'd98;
  localparam logic [CP_W-1:0] CH_LOWER_F    = 21'd102;
  localparam logic [CP_W-1:0] CH_LOWER_N    = 21'd110;
  localparam logic [CP_W-1:0] CH_LOWER_R    = 21'd114;
  localparam logic [CP_W-1:0] CH_LOWER_T    = 21'd116;
  localparam logic [CP_W-1:0] CH_LOWER_V    = 21'd118;
  localparam logic [CP_W-1:0] CH_LOWER_Z    = 21'd122;
  localparam logic [CP_W-1:0] CH_LBRACE     = 21'd123;
  localparam logic [CP_W-1:0] CH_RBRACE     = 21'd125;

  typedef enum logic [2:0] {
    MODE_IDLE,
    MODE_NUMBER,
    MODE_NAME,
    MODE_STRING,
    MODE_ESCAPE,
    MODE_DOT1,
    MODE_DOT2,
    MODE_HALT
  } mode_t;

  typedef enum logic [3:0] {
    KIND_NAME      = 4'd0,
    KIND_ASSIGN    = 4'd1,
    KIND_DOT       = 4'd2,
    KIND_ELLIPSIS  = 4'd3,
    KIND_COMMA     = 4'd4,
    KIND_STRING    = 4'd5,
    KIND_LBRACE    = 4'd6,
    KIND_RBRACE    = 4'd7,
    KIND_LPAREN    = 4'd8,
    KIND_RPAREN    = 4'd9,
    KIND_GREATER   = 4'd10,
    KIND_SEMICOLON = 4'd11,
    KIND_INTEGER   = 4'd12,
    KIND_EOF       = 4'd13,
    KIND_TEXT      = 4'd14,
    KIND_ERROR     = 4'd15
  } kind_t;

  typedef enum logic [2:0] {
    ERR_NONE         = 3'd0,
    ERR_UNEXPECTED   = 3'd1,
    ERR_BAD_ESCAPE   = 3'd2,
    ERR_UNTERMINATED = 3'd3,
    ERR_TWO_DOTS     = 3'd4
  } err_t;

  typedef struct packed {
    kind_t              kind;
    logic [VALUE_W-1:0] value;
    err_t               error_code;
    logic [LINE_W-1:0]  line;
    logic [COL_W-1:0]   column;
  } result_t;

  typedef struct packed {
    logic [1:0] count;
    result_t    first;
    result_t    second;
  } step_t;

  typedef struct packed {
    mode_t   mode;
    logic    emit;
    logic    set_start;
    logic    load_num;
    result_t res;
  } idle_t;

  typedef struct packed {
    logic       ok;
    logic [6:0] code;
  } escape_t;

  function automatic result_t make_result(input kind_t k, input logic [VALUE_W-1:0] v,
                                          input err_t e, input logic [LINE_W-1:0] l,
                                          input logic [COL_W-1:0] c);
    result_t r;
    r.kind       = k;
    r.value      = v;
    r.error_code = e;
    r.line       = l;
    r.column     = c;
    return r;
  endfunction

endpackage

// File: rtl/core/source_token_scanner.sv
// ----------------------------------------------------------------------------
// source_token_scanner
// An item's first result is presented in the cycle after accept. Throughput: one
// item per cycle while items give at most one result and out_ready is high; an
// item with two results holds in_ready low while both sit in the two-entry
// result register. rst (synchronous) clears scan state to idle, position to
// line 1 column 0, the accumulator to 0, tab advance to 4 and the result queue.
// ----------------------------------------------------------------------------
module source_token_scanner (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic [sts_pkg::TAB_W-1:0]     tab_advance,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [sts_pkg::CP_W-1:0]      codepoint,
  input  logic                          end_of_input,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [3:0]                    kind,
  output logic [sts_pkg::VALUE_W-1:0]   value,
  output logic [2:0]                    error_code,
  output logic [sts_pkg::LINE_W-1:0]    line,
  output logic [sts_pkg::COL_W-1:0]     column,
  output logic                          last
);

  logic             fire;
  sts_pkg::step_t   step;
  sts_pkg::result_t head;

  assign fire = in_valid && in_ready;

  sts_scan u_scan (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .tab_advance  (tab_advance),
    .fire         (fire),
    .codepoint    (codepoint),
    .end_of_input (end_of_input),
    .step         (step)
  );

  sts_out u_out (
    .clk       (clk),
    .rst       (rst),
    .fire      (fire),
    .step      (step),
    .out_ready (out_ready),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .head      (head),
    .last      (last)
  );

  assign kind       = head.kind;
  assign value      = head.value;
  assign error_code = head.error_code;
  assign line       = head.line;
  assign column     = head.column;

`ifndef SYNTH
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !last |-> !in_ready)
    else $error("item accepted while a second result is pending");

  assert property (@(posedge clk) disable iff (rst)
    out_valid && kind != sts_pkg::KIND_ERROR |-> error_code == sts_pkg::ERR_NONE)
    else $error("error code on a non-error result");

  assert property (@(posedge clk) disable iff (rst)
    out_valid && kind == sts_pkg::KIND_EOF |-> last)
    else $error("eof result not last of its item");
`endif

endmodule

// File: rtl/core/sts_scan.sv
// ----------------------------------------------------------------------------
// sts_scan
// Scanner state, location tracking and per-item result generation.
// ----------------------------------------------------------------------------
module sts_scan (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_write,
  input  logic [sts_pkg::TAB_W-1:0]   tab_advance,
  input  logic                        fire,
  input  logic [sts_pkg::CP_W-1:0]    codepoint,
  input  logic                        end_of_input,
  output sts_pkg::step_t              step
);

  logic [sts_pkg::TAB_W-1:0]   tab;
  sts_pkg::mode_t              mode;
  sts_pkg::mode_t              mode_next;
  logic [sts_pkg::VALUE_W-1:0] acc;
  logic [sts_pkg::VALUE_W-1:0] acc_next;
  logic [sts_pkg::LINE_W-1:0]  cur_line;
  logic [sts_pkg::LINE_W-1:0]  cur_line_next;
  logic [sts_pkg::COL_W-1:0]   cur_col;
  logic [sts_pkg::COL_W-1:0]   cur_col_next;
  logic [sts_pkg::LINE_W-1:0]  start_line;
  logic [sts_pkg::LINE_W-1:0]  start_line_next;
  logic [sts_pkg::COL_W-1:0]   start_col;
  logic [sts_pkg::COL_W-1:0]   start_col_next;

  logic [sts_pkg::LINE_W-1:0]  adv_line;
  logic [sts_pkg::COL_W-1:0]   adv_col;
  logic [sts_pkg::COL_W:0]     col_sum;
  logic [sts_pkg::VALUE_W-1:0] cp_ext;
  logic                        is_digit;
  logic                        is_name_char;
  logic [sts_pkg::VALUE_W+3:0] mac;
  logic [sts_pkg::VALUE_W-1:0] mac_sat;
  sts_pkg::idle_t              idle;
  sts_pkg::escape_t            esc;
  sts_pkg::result_t            p;
  sts_pkg::result_t            q;
  logic                        pv;
  logic                        qv;
  logic                        use_idle;

  function automatic sts_pkg::idle_t idle_scan(input logic [sts_pkg::CP_W-1:0] c,
                                               input logic [sts_pkg::LINE_W-1:0] l,
                                               input logic [sts_pkg::COL_W-1:0] col);
    sts_pkg::idle_t r;
    r.mode      = sts_pkg::MODE_IDLE;
    r.emit      = 1'b1;
    r.set_start = 1'b0;
    r.load_num  = 1'b0;
    r.res       = sts_pkg::make_result(sts_pkg::KIND_ERROR, '0, sts_pkg::ERR_NONE, l, col);
    if (c inside {sts_pkg::CH_TAB, sts_pkg::CH_LF, sts_pkg::CH_CR, sts_pkg::CH_SPACE}) begin
      r.emit = 1'b0;
    end else if (c inside {[sts_pkg::CH_ZERO:sts_pkg::CH_NINE]}) begin
      r.emit      = 1'b0;
      r.mode      = sts_pkg::MODE_NUMBER;
      r.set_start = 1'b1;
      r.load_num  = 1'b1;
    end else if (c inside {[sts_pkg::CH_LOWER_A:sts_pkg::CH_LOWER_Z],
                           [sts_pkg::CH_UPPER_A:sts_pkg::CH_UPPER_Z]}) begin
      r.mode      = sts_pkg::MODE_NAME;
      r.res.kind  = sts_pkg::KIND_NAME;
      r.res.value = {{sts_pkg::PAD_W{1'b0}}, c};
    end else begin
      case (c)
        sts_pkg::CH_QUOTE: begin
          r.mode     = sts_pkg::MODE_STRING;
          r.res.kind = sts_pkg::KIND_STRING;
        end
        sts_pkg::CH_DOT: begin
          r.emit      = 1'b0;
          r.mode      = sts_pkg::MODE_DOT1;
          r.set_start = 1'b1;
        end
        sts_pkg::CH_EQUAL:   r.res.kind = sts_pkg::KIND_ASSIGN;
        sts_pkg::CH_COMMA:   r.res.kind = sts_pkg::KIND_COMMA;
        sts_pkg::CH_LBRACE:  r.res.kind = sts_pkg::KIND_LBRACE;
        sts_pkg::CH_RBRACE:  r.res.kind = sts_pkg::KIND_RBRACE;
        sts_pkg::CH_LPAREN:  r.res.kind = sts_pkg::KIND_LPAREN;
        sts_pkg::CH_RPAREN:  r.res.kind = sts_pkg::KIND_RPAREN;
        sts_pkg::CH_GREATER: r.res.kind = sts_pkg::KIND_GREATER;
        sts_pkg::CH_SEMI:    r.res.kind = sts_pkg::KIND_SEMICOLON;
        default: begin
          r.mode           = sts_pkg::MODE_HALT;
          r.res.value      = {{sts_pkg::PAD_W{1'b0}}, c};
          r.res.error_code = sts_pkg::ERR_UNEXPECTED;
        end
      endcase
    end
    return r;
  endfunction

  function automatic sts_pkg::escape_t escape_map(input logic [sts_pkg::CP_W-1:0] c);
    sts_pkg::escape_t r;
    r.ok   = 1'b1;
    r.code = c[6:0];
    case (c)
      sts_pkg::CH_ZERO:      r.code = 7'd0;
      sts_pkg::CH_LOWER_A:   r.code = 7'd7;
      sts_pkg::CH_LOWER_B:   r.code = 7'd8;
      sts_pkg::CH_LOWER_T:   r.code = 7'd9;
      sts_pkg::CH_LOWER_N:   r.code = 7'd10;
      sts_pkg::CH_LOWER_V:   r.code = 7'd11;
      sts_pkg::CH_LOWER_F:   r.code = 7'd12;
      sts_pkg::CH_LOWER_R:   r.code = 7'd13;
      sts_pkg::CH_BACKSLASH: r.code = c[6:0];
      sts_pkg::CH_APOS:      r.code = c[6:0];
      sts_pkg::CH_QUOTE:     r.code = c[6:0];
      default:               r.ok   = 1'b0;
    endcase
    return r;
  endfunction

  assign cp_ext       = {{sts_pkg::PAD_W{1'b0}}, codepoint};
  assign is_digit     = codepoint inside {[sts_pkg::CH_ZERO:sts_pkg::CH_NINE]};
  assign is_name_char = codepoint inside {[sts_pkg::CH_ZERO:sts_pkg::CH_NINE],
                                          [sts_pkg::CH_LOWER_A:sts_pkg::CH_LOWER_Z],
                                          [sts_pkg::CH_UPPER_A:sts_pkg::CH_UPPER_Z],
                                          sts_pkg::CH_UNDERSCORE};
  assign idle         = idle_scan(codepoint, adv_line, adv_col);
  assign esc          = escape_map(codepoint);

  // acc * 10 + digit, saturating
  assign mac     = ({4'b0, acc} << 3) + ({4'b0, acc} << 1) +
                   {{sts_pkg::VALUE_W{1'b0}}, codepoint[3:0]};
  assign mac_sat = (mac[sts_pkg::VALUE_W+3:sts_pkg::VALUE_W] != 4'b0) ? '1 :
                   mac[sts_pkg::VALUE_W-1:0];

  always_comb begin
    adv_line = cur_line;
    adv_col  = cur_col;
    col_sum  = {1'b0, cur_col} + ((codepoint == sts_pkg::CH_TAB) ?
               {{(sts_pkg::COL_W+1-sts_pkg::TAB_W){1'b0}}, tab} :
               {{sts_pkg::COL_W{1'b0}}, 1'b1});
    if (codepoint == sts_pkg::CH_LF) begin
      if (cur_line != sts_pkg::LINE_MAX) begin
        adv_line = cur_line + sts_pkg::LINE_ONE;
      end
      adv_col = '0;
    end else begin
      adv_col = col_sum[sts_pkg::COL_W] ? sts_pkg::COL_MAX : col_sum[sts_pkg::COL_W-1:0];
    end
  end

  always_comb begin
    mode_next = mode;
    if (mode != sts_pkg::MODE_HALT) begin
      if (end_of_input) begin
        case (mode)
          sts_pkg::MODE_STRING, sts_pkg::MODE_ESCAPE, sts_pkg::MODE_DOT2:
            mode_next = sts_pkg::MODE_HALT;
          default: mode_next = sts_pkg::MODE_IDLE;
        endcase
      end else begin
        case (mode)
          sts_pkg::MODE_IDLE:   mode_next = idle.mode;
          sts_pkg::MODE_NUMBER: mode_next = is_digit ? sts_pkg::MODE_NUMBER : idle.mode;
          sts_pkg::MODE_NAME:   mode_next = is_name_char ? sts_pkg::MODE_NAME : idle.mode;
          sts_pkg::MODE_STRING: begin
            if (codepoint == sts_pkg::CH_QUOTE) begin
              mode_next = sts_pkg::MODE_IDLE;
            end else if (codepoint == sts_pkg::CH_BACKSLASH) begin
              mode_next = sts_pkg::MODE_ESCAPE;
            end
          end
          sts_pkg::MODE_ESCAPE: mode_next = esc.ok ? sts_pkg::MODE_STRING : sts_pkg::MODE_HALT;
          sts_pkg::MODE_DOT1:
            mode_next = (codepoint == sts_pkg::CH_DOT) ? sts_pkg::MODE_DOT2 : idle.mode;
          sts_pkg::MODE_DOT2:
            mode_next = (codepoint == sts_pkg::CH_DOT) ? sts_pkg::MODE_IDLE : sts_pkg::MODE_HALT;
          default: mode_next = sts_pkg::MODE_HALT;
        endcase
      end
    end
  end

  always_comb begin
    p               = sts_pkg::make_result(sts_pkg::KIND_EOF, '0, sts_pkg::ERR_NONE,
                                           cur_line, cur_col);
    q               = p;
    pv              = 1'b0;
    qv              = 1'b0;
    use_idle        = 1'b0;
    acc_next        = acc;
    cur_line_next   = cur_line;
    cur_col_next    = cur_col;
    start_line_next = start_line;
    start_col_next  = start_col;
    if (mode != sts_pkg::MODE_HALT) begin
      if (end_of_input) begin
        acc_next = '0;
        qv       = 1'b1;
        case (mode)
          sts_pkg::MODE_NUMBER: begin
            pv = 1'b1;
            p  = sts_pkg::make_result(sts_pkg::KIND_INTEGER, acc, sts_pkg::ERR_NONE,
                                      start_line, start_col);
          end
          sts_pkg::MODE_DOT1: begin
            pv = 1'b1;
            p  = sts_pkg::make_result(sts_pkg::KIND_DOT, '0, sts_pkg::ERR_NONE,
                                      start_line, start_col);
          end
          sts_pkg::MODE_STRING, sts_pkg::MODE_ESCAPE: begin
            pv = 1'b1;
            qv = 1'b0;
            p  = sts_pkg::make_result(sts_pkg::KIND_ERROR, '0, sts_pkg::ERR_UNTERMINATED,
                                      cur_line, cur_col);
          end
          sts_pkg::MODE_DOT2: begin
            pv = 1'b1;
            qv = 1'b0;
            p  = sts_pkg::make_result(sts_pkg::KIND_ERROR, '0, sts_pkg::ERR_TWO_DOTS,
                                      cur_line, cur_col);
          end
          default: ;
        endcase
      end else begin
        cur_line_next = adv_line;
        cur_col_next  = adv_col;
        case (mode)
          sts_pkg::MODE_IDLE: use_idle = 1'b1;
          sts_pkg::MODE_NUMBER: begin
            if (is_digit) begin
              acc_next = mac_sat;
            end else begin
              pv       = 1'b1;
              p        = sts_pkg::make_result(sts_pkg::KIND_INTEGER, acc, sts_pkg::ERR_NONE,
                                              start_line, start_col);
              acc_next = '0;
              use_idle = 1'b1;
            end
          end
          sts_pkg::MODE_NAME: begin
            if (is_name_char) begin
              pv = 1'b1;
              p  = sts_pkg::make_result(sts_pkg::KIND_TEXT, cp_ext, sts_pkg::ERR_NONE,
                                        adv_line, adv_col);
            end else begin
              use_idle = 1'b1;
            end
          end
          sts_pkg::MODE_STRING: begin
            if (codepoint != sts_pkg::CH_QUOTE && codepoint != sts_pkg::CH_BACKSLASH) begin
              pv = 1'b1;
              p  = sts_pkg::make_result(sts_pkg::KIND_TEXT, cp_ext, sts_pkg::ERR_NONE,
                                        adv_line, adv_col);
            end
          end
          sts_pkg::MODE_ESCAPE: begin
            pv = 1'b1;
            if (esc.ok) begin
              p = sts_pkg::make_result(sts_pkg::KIND_TEXT,
                                       {{(sts_pkg::VALUE_W-7){1'b0}}, esc.code},
                                       sts_pkg::ERR_NONE, adv_line, adv_col);
            end else begin
              p = sts_pkg::make_result(sts_pkg::KIND_ERROR, cp_ext, sts_pkg::ERR_BAD_ESCAPE,
                                       adv_line, adv_col);
            end
          end
          sts_pkg::MODE_DOT1: begin
            if (codepoint != sts_pkg::CH_DOT) begin
              pv       = 1'b1;
              p        = sts_pkg::make_result(sts_pkg::KIND_DOT, '0, sts_pkg::ERR_NONE,
                                              start_line, start_col);
              use_idle = 1'b1;
            end
          end
          sts_pkg::MODE_DOT2: begin
            pv = 1'b1;
            if (codepoint == sts_pkg::CH_DOT) begin
              p = sts_pkg::make_result(sts_pkg::KIND_ELLIPSIS, '0, sts_pkg::ERR_NONE,
                                       start_line, start_col);
            end else begin
              p = sts_pkg::make_result(sts_pkg::KIND_ERROR, cp_ext, sts_pkg::ERR_TWO_DOTS,
                                       adv_line, adv_col);
            end
          end
          default: ;
        endcase
        if (use_idle) begin
          qv = idle.emit;
          q  = idle.res;
          if (idle.set_start) begin
            start_line_next = adv_line;
            start_col_next  = adv_col;
          end
          if (idle.load_num) begin
            acc_next = {{(sts_pkg::VALUE_W-4){1'b0}}, codepoint[3:0]};
          end
        end
      end
    end
    step.count  = {pv & qv, pv ^ qv};
    step.first  = pv ? p : q;
    step.second = q;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tab        <= sts_pkg::TAB_RESET;
      mode       <= sts_pkg::MODE_IDLE;
      acc        <= '0;
      cur_line   <= sts_pkg::LINE_ONE;
      cur_col    <= '0;
      start_line <= sts_pkg::LINE_ONE;
      start_col  <= '0;
    end else begin
      if (cfg_write) begin
        tab <= tab_advance;
      end
      if (fire) begin
        mode       <= mode_next;
        acc        <= acc_next;
        cur_line   <= cur_line_next;
        cur_col    <= cur_col_next;
        start_line <= start_line_next;
        start_col  <= start_col_next;
      end
    end
  end

endmodule

// File: rtl/core/sts_out.sv
// ----------------------------------------------------------------------------
// sts_out
// Two-entry result register; presents the results of one item in order.
// ----------------------------------------------------------------------------
module sts_out (
  input  logic             clk,
  input  logic             rst,
  input  logic             fire,
  input  sts_pkg::step_t   step,
  input  logic             out_ready,
  output logic             in_ready,
  output logic             out_valid,
  output sts_pkg::result_t head,
  output logic             last
);

  logic [1:0]       count;
  sts_pkg::result_t slot0;
  sts_pkg::result_t slot1;
  logic             pop;

  assign out_valid = count != 2'd0;
  assign pop       = out_valid && out_ready;
  assign last      = count == 2'd1;
  assign head      = slot0;
  assign in_ready  = count == 2'd0 || (count == 2'd1 && out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else if (fire) begin
      count <= step.count;
    end else if (pop) begin
      count <= count - 2'd1;
    end
  end

  // load both results on accept; advance the second result to the head on pop
  always_ff @(posedge clk) begin
    if (fire) begin
      slot0 <= step.first;
      slot1 <= step.second;
    end else if (pop) begin
      slot0 <= slot1;
    end
  end

endmodule
